### src/sreu_pkg.sv
// Shared types, opcodes and sizes of the small RISC execute unit.
package sreu_pkg;

	localparam int NUM_REGS_DEF  = 32;
	localparam int MEM_WORDS_DEF = 1024;
	localparam int QDEPTH        = 2;

	localparam logic [3:0] CMD_LI   = 4'd0;
	localparam logic [3:0] CMD_LW   = 4'd1;
	localparam logic [3:0] CMD_SW   = 4'd2;
	localparam logic [3:0] CMD_ADD  = 4'd3;
	localparam logic [3:0] CMD_SUB  = 4'd4;
	localparam logic [3:0] CMD_MUL  = 4'd5;
	localparam logic [3:0] CMD_DIV  = 4'd6;
	localparam logic [3:0] CMD_BEQ  = 4'd7;
	localparam logic [3:0] CMD_BNE  = 4'd8;
	localparam logic [3:0] CMD_BGT  = 4'd9;
	localparam logic [3:0] CMD_BLT  = 4'd10;
	localparam logic [3:0] CMD_ADDI = 4'd11;
	localparam logic [3:0] CMD_SUBI = 4'd12;
	localparam logic [3:0] CMD_MFHI = 4'd13;
	localparam logic [3:0] CMD_MFLO = 4'd14;
	localparam logic [3:0] CMD_BAD  = 4'd15;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BAD  = 2'd1;
	localparam logic [1:0] ST_ADDR = 2'd2;
	localparam logic [1:0] ST_DIVZ = 2'd3;

	typedef enum logic [2:0] {
		CL_ALU,
		CL_MEM,
		CL_DIV,
		CL_BR,
		CL_MOVE,
		CL_BAD
	} cls_t;

	typedef struct packed {
		cls_t        cls;
		logic [3:0]  cmd;
		logic [4:0]  rd;
		logic [4:0]  ra;
		logic [4:0]  rb;
		logic [31:0] imm;
		logic [15:0] tgt;
	} item_t;

endpackage

### src/sreu_front.sv
// Front end: accepts instructions, classifies them and pushes them to the queue.
module sreu_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         cmd,
	input  logic [4:0]         dest_reg,
	input  logic [4:0]         src_a_reg,
	input  logic [4:0]         src_b_reg,
	input  logic signed [31:0] immediate,
	input  logic [15:0]        jump_target,
	input  logic               clearing,
	input  logic               q_full,
	output logic               q_push,
	output sreu_pkg::item_t    q_item
);
	sreu_pkg::cls_t cls;
	logic           seen_q;

	always_comb begin
		unique case (cmd) inside
			sreu_pkg::CMD_LI, sreu_pkg::CMD_ADD, sreu_pkg::CMD_SUB, sreu_pkg::CMD_MUL,
			sreu_pkg::CMD_ADDI, sreu_pkg::CMD_SUBI:  cls = sreu_pkg::CL_ALU;
			sreu_pkg::CMD_LW, sreu_pkg::CMD_SW:      cls = sreu_pkg::CL_MEM;
			sreu_pkg::CMD_DIV:                       cls = sreu_pkg::CL_DIV;
			sreu_pkg::CMD_BEQ, sreu_pkg::CMD_BNE, sreu_pkg::CMD_BGT,
			sreu_pkg::CMD_BLT:                       cls = sreu_pkg::CL_BR;
			sreu_pkg::CMD_MFHI, sreu_pkg::CMD_MFLO:  cls = sreu_pkg::CL_MOVE;
			default:                                 cls = sreu_pkg::CL_BAD;
		endcase
	end

	// Hold off transfers until a clock edge after reset has set seen_q.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else begin
			seen_q <= 1'b1;
		end
	end

	assign in_stall = !seen_q || clearing || q_full;
	assign q_push   = in_valid && !in_stall;

	assign q_item.cls = cls;
	assign q_item.cmd = cmd;
	assign q_item.rd  = dest_reg;
	assign q_item.ra  = src_a_reg;
	assign q_item.rb  = src_b_reg;
	assign q_item.imm = immediate;
	assign q_item.tgt = jump_target;

endmodule

### src/sreu_queue.sv
// Short instruction queue between front and back end.
module sreu_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sreu_pkg::item_t push_item,
	input  logic            pop,
	output sreu_pkg::item_t head,
	output logic            empty,
	output logic            full
);
	localparam int PW = $clog2(sreu_pkg::QDEPTH);
	localparam int CW = $clog2(sreu_pkg::QDEPTH + 1);

	sreu_pkg::item_t slot_q [sreu_pkg::QDEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [CW-1:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(sreu_pkg::QDEPTH));
	assign head  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_item;
		end
	end

	// Advance pointers; wrap at the queue depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(sreu_pkg::QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(sreu_pkg::QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### src/sreu_back.sv
// Back end: register file, data memory, divider and result register.
module sreu_back #(
	parameter int NUM_REGS  = sreu_pkg::NUM_REGS_DEF,
	parameter int MEM_WORDS = sreu_pkg::MEM_WORDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  sreu_pkg::item_t    head,
	output logic               q_pop,
	output logic               clearing,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               branch_taken,
	output logic [15:0]        branch_target,
	output logic [1:0]         status,
	output logic signed [31:0] written_value
);
	localparam int RW = $clog2(NUM_REGS);
	localparam int AW = $clog2(MEM_WORDS);

	typedef enum logic [2:0] {S_IDLE, S_RD, S_RD2, S_DIV, S_EXEC} state_t;

	state_t          state_q;
	sreu_pkg::item_t it_q;
	logic            out_valid_q;
	logic            taken_q;
	logic [15:0]     tgt_out_q;
	logic [1:0]      status_q;
	logic [31:0]     wv_q;
	logic [31:0]     hi_q, lo_q;
	logic [15:0]     last_tgt_q;
	logic [31:0]     vra_q, vrb_q, va_q, mul_q;
	logic            addr_ok_q;
	logic [AW-1:0]   addr_q;
	logic [31:0]     div_n_q, div_r_q, div_d_q;
	logic [4:0]      div_cnt_q;
	logic [AW:0]     clr_cnt_q;

	logic [31:0]     rf_mem [NUM_REGS];
	logic            vld_q  [NUM_REGS];
	logic [31:0]     rf_a_q, rf_b_q;
	logic [31:0]     dm_mem [MEM_WORDS];
	logic [31:0]     dm_rd_q;

	logic [4:0]      sel_a;
	logic            a_ok, b_ok, wr_in_rng;
	logic [63:0]     mulp;
	logic [33:0]     asum;
	logic [32:0]     dtmp, ddiff;
	logic            out_free, fire;
	logic            ex_taken;
	logic [1:0]      ex_status;
	logic [31:0]     ex_wv, ex_q, ex_r;
	logic            rf_we, dm_we, hilo_we;

	assign clearing = (clr_cnt_q < (AW + 1)'(MEM_WORDS));
	assign q_pop    = (state_q == S_IDLE) && !q_empty && !clearing;
	assign out_free = !out_valid_q || !out_stall;
	assign fire     = (state_q == S_EXEC) && out_free;

	// Register file reads: port a reads source a while idle, the destination afterwards; port b reads the head's source b.
	assign sel_a     = (state_q == S_IDLE) ? head.ra : it_q.rd;
	assign a_ok      = ({1'b0, sel_a} < 6'(NUM_REGS)) && vld_q[sel_a[RW-1:0]];
	assign b_ok      = ({1'b0, head.rb} < 6'(NUM_REGS)) && vld_q[head.rb[RW-1:0]];
	assign wr_in_rng = ({1'b0, it_q.rd} < 6'(NUM_REGS));

	always_ff @(posedge clk) begin
		rf_a_q <= a_ok ? rf_mem[sel_a[RW-1:0]] : '0;
		rf_b_q <= b_ok ? rf_mem[head.rb[RW-1:0]] : '0;
		if (rf_we) begin
			rf_mem[it_q.rd[RW-1:0]] <= ex_wv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (rf_we) begin
			vld_q[it_q.rd[RW-1:0]] <= 1'b1;
		end
	end

	// Data memory: zero sweep after reset, then one port for loads and stores.
	always_ff @(posedge clk) begin
		if (clearing) begin
			dm_mem[clr_cnt_q[AW-1:0]] <= '0;
		end else if (dm_we) begin
			dm_mem[addr_q] <= va_q;
		end
		dm_rd_q <= dm_mem[addr_q];
	end

	assign mulp  = {32'd0, rf_a_q} * {32'd0, rf_b_q};
	assign asum  = {{2{rf_a_q[31]}}, rf_a_q} + {{2{it_q.imm[31]}}, it_q.imm};
	assign dtmp  = {div_r_q, div_n_q[31]};
	assign ddiff = dtmp - {1'b0, div_d_q};
	assign ex_q  = (va_q[31] ^ vra_q[31]) ? -div_n_q : div_n_q;
	assign ex_r  = va_q[31] ? -div_r_q : div_r_q;

	always_comb begin
		ex_taken  = 1'b0;
		ex_status = sreu_pkg::ST_OK;
		ex_wv     = '0;
		rf_we     = 1'b0;
		dm_we     = 1'b0;
		hilo_we   = 1'b0;
		unique case (it_q.cmd)
			sreu_pkg::CMD_LI:   begin ex_wv = it_q.imm; rf_we = 1'b1; end
			sreu_pkg::CMD_LW:   begin
				if (addr_ok_q) begin
					ex_wv = dm_rd_q;
					rf_we = 1'b1;
				end else begin
					ex_status = sreu_pkg::ST_ADDR;
				end
			end
			sreu_pkg::CMD_SW:   begin
				if (addr_ok_q) begin
					ex_wv = va_q;
					dm_we = 1'b1;
				end else begin
					ex_status = sreu_pkg::ST_ADDR;
				end
			end
			sreu_pkg::CMD_ADD:  begin ex_wv = vra_q + vrb_q; rf_we = 1'b1; end
			sreu_pkg::CMD_SUB:  begin ex_wv = vra_q - vrb_q; rf_we = 1'b1; end
			sreu_pkg::CMD_MUL:  begin ex_wv = mul_q; rf_we = 1'b1; end
			sreu_pkg::CMD_DIV:  begin
				if (vra_q == '0) begin
					ex_status = sreu_pkg::ST_DIVZ;
				end else begin
					hilo_we = 1'b1;
				end
			end
			sreu_pkg::CMD_BEQ:  ex_taken = (va_q == vra_q);
			sreu_pkg::CMD_BNE:  ex_taken = (va_q != vra_q);
			sreu_pkg::CMD_BGT:  ex_taken = ($signed(va_q) > $signed(vra_q));
			sreu_pkg::CMD_BLT:  ex_taken = ($signed(va_q) < $signed(vra_q));
			sreu_pkg::CMD_ADDI: begin ex_wv = vra_q + it_q.imm; rf_we = 1'b1; end
			sreu_pkg::CMD_SUBI: begin ex_wv = vra_q - it_q.imm; rf_we = 1'b1; end
			sreu_pkg::CMD_MFHI: begin ex_wv = hi_q; rf_we = 1'b1; end
			sreu_pkg::CMD_MFLO: begin ex_wv = lo_q; rf_we = 1'b1; end
			default:            ex_status = sreu_pkg::ST_BAD;
		endcase
		rf_we   = rf_we && wr_in_rng && fire;
		dm_we   = dm_we && fire;
		hilo_we = hilo_we && fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			it_q        <= '0;
			out_valid_q <= 1'b0;
			taken_q     <= 1'b0;
			tgt_out_q   <= '0;
			status_q    <= sreu_pkg::ST_OK;
			wv_q        <= '0;
			hi_q        <= '0;
			lo_q        <= '0;
			last_tgt_q  <= '0;
			vra_q       <= '0;
			vrb_q       <= '0;
			va_q        <= '0;
			mul_q       <= '0;
			addr_ok_q   <= 1'b0;
			addr_q      <= '0;
			div_n_q     <= '0;
			div_r_q     <= '0;
			div_d_q     <= '0;
			div_cnt_q   <= '0;
			clr_cnt_q   <= '0;
		end else begin
			if (clearing) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						it_q    <= head;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					vra_q     <= rf_a_q;
					vrb_q     <= rf_b_q;
					mul_q     <= mulp[31:0];
					addr_ok_q <= !asum[33] && (asum[32:0] < 33'(MEM_WORDS));
					addr_q    <= asum[AW-1:0];
					state_q   <= S_RD2;
				end
				S_RD2: begin
					va_q      <= rf_a_q;
					div_n_q   <= rf_a_q[31] ? -rf_a_q : rf_a_q;
					div_d_q   <= vra_q[31] ? -vra_q : vra_q;
					div_r_q   <= '0;
					div_cnt_q <= '0;
					state_q   <= (it_q.cls == sreu_pkg::CL_DIV && vra_q != '0) ? S_DIV : S_EXEC;
				end
				S_DIV: begin
					// One restoring step per cycle on the magnitudes.
					if (!ddiff[32]) begin
						div_r_q <= ddiff[31:0];
					end else begin
						div_r_q <= dtmp[31:0];
					end
					div_n_q   <= {div_n_q[30:0], !ddiff[32]};
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 5'd31) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						taken_q     <= ex_taken;
						tgt_out_q   <= ex_taken ? it_q.tgt : last_tgt_q;
						status_q    <= ex_status;
						wv_q        <= ex_wv;
						if (ex_taken) begin
							last_tgt_q <= it_q.tgt;
						end
						if (hilo_we) begin
							lo_q <= ex_q;
							hi_q <= ex_r;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign branch_taken  = taken_q;
	assign branch_target = tgt_out_q;
	assign status        = status_q;
	assign written_value = wv_q;

	a_no_out_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !out_valid_q)
		else $error("result presented during memory clear");

	a_div_state_only_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (it_q.cls == sreu_pkg::CL_DIV))
		else $error("divider running for a non-divide instruction");

	a_error_writes_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != sreu_pkg::ST_OK) |-> (wv_q == '0 && !taken_q))
		else $error("error result carries a written value");

endmodule

### src/small_risc_execute_unit_top.sv
// Top level of the small RISC execute unit: front end, queue and back end.
// Path: an input transfer goes through the queue, two register file reads and
//   execute to the result; a divide also passes through the radix-2 divider.
// The back end sequencer takes a new instruction only once the previous one
//   has left execute; a divide occupies it for the divider steps too.
// Reset: arst_n clears control state, register file valid bits, hi, lo and the
//   branch target, then a clear sweep zeroes data memory one word at a time,
//   during which no input is taken.
module small_risc_execute_unit_top #(
	parameter int NUM_REGS  = sreu_pkg::NUM_REGS_DEF,
	parameter int MEM_WORDS = sreu_pkg::MEM_WORDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         cmd,
	input  logic [4:0]         dest_reg,
	input  logic [4:0]         src_a_reg,
	input  logic [4:0]         src_b_reg,
	input  logic signed [31:0] immediate,
	input  logic [15:0]        jump_target,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic               branch_taken,
	output logic [15:0]        branch_target,
	output logic [1:0]         status,
	output logic signed [31:0] written_value
);
	sreu_pkg::item_t push_item;
	sreu_pkg::item_t head;
	logic            push, pop, q_empty, q_full, clearing;

	// Decode and push each transfer into the queue.
	sreu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.dest_reg    (dest_reg),
		.src_a_reg   (src_a_reg),
		.src_b_reg   (src_b_reg),
		.immediate   (immediate),
		.jump_target (jump_target),
		.clearing    (clearing),
		.q_full      (q_full),
		.q_push      (push),
		.q_item      (push_item)
	);

	// Decouple front and back so either can stall alone.
	sreu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	// Execute in order and hold each result until its transfer.
	sreu_back #(
		.NUM_REGS  (NUM_REGS),
		.MEM_WORDS (MEM_WORDS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.head          (head),
		.q_pop         (pop),
		.clearing      (clearing),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.branch_taken  (branch_taken),
		.branch_target (branch_target),
		.status        (status),
		.written_value (written_value)
	);

endmodule
